### sv/io_request_latency_monitor_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the request latency monitor
// Shared property wrappers, clocked on i_clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef IO_REQUEST_LATENCY_MONITOR_TOP_ASSERT_SVH
`define IO_REQUEST_LATENCY_MONITOR_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IRLM_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("irlm assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define IRLM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("irlm assertion failed");

`endif

### sv/irlm_pkg.sv
// ----------------------------------------------------------------------------
// Request latency monitor package
// Shared types, register indexes and the request kind decode.
// ----------------------------------------------------------------------------
package irlm_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int SECTOR_SHIFT      = 9;

    typedef logic [1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_ENABLE      = 2'd0;
    localparam t_cfg_idx CFG_TARGET_PID  = 2'd1;
    localparam t_cfg_idx CFG_MIN_LATENCY = 2'd2;

    localparam logic ACT_ISSUE    = 1'b0;
    localparam logic ACT_COMPLETE = 1'b1;

    localparam logic [7:0] CHAR_R = 8'h52;
    localparam logic [7:0] CHAR_W = 8'h57;
    localparam logic [7:0] CHAR_D = 8'h44;
    localparam logic [7:0] CHAR_F = 8'h46;

    localparam logic [2:0] OP_READ    = 3'd1;
    localparam logic [2:0] OP_WRITE   = 3'd2;
    localparam logic [2:0] OP_DISCARD = 3'd3;
    localparam logic [2:0] OP_FLUSH   = 3'd4;
    localparam logic [2:0] OP_OTHER   = 3'd5;

    typedef struct packed {
        logic        action;
        logic [31:0] device;
        logic [63:0] sector;
        logic [63:0] time_ns;
        logic [22:0] pid;
        logic [7:0]  op_char;
        logic [31:0] sector_count;
        logic [63:0] name_low;
        logic [63:0] name_high;
    } t_req;

    typedef struct packed {
        logic [63:0] req_latency;
        logic [22:0] req_pid;
        logic [31:0] req_device;
        logic [63:0] req_sector;
        logic [31:0] req_sectors;
        logic [2:0]  op_code;
        logic [40:0] byte_count;
        logic [63:0] req_name_low;
        logic [63:0] req_name_high;
        logic [63:0] complete_count;
        logic [63:0] total_latency;
        logic [63:0] max_latency;
    } t_rec;

    typedef struct packed {
        logic        valid;
        logic [31:0] device;
        logic [63:0] sector;
        logic [63:0] start_time;
        logic [22:0] pid;
        logic [7:0]  op_char;
        logic [31:0] sector_count;
        logic [63:0] name_low;
        logic [63:0] name_high;
    } t_entry;

    typedef struct packed {
        logic clear;
        logic start;
        logic scan;
        logic write;
        logic free;
        logic report;
    } t_cmd;

    typedef struct packed {
        logic enable;
        logic is_complete;
        logic clear_done;
        logic scan_done;
        logic hit;
        logic slot_ok;
        logic report_done;
    } t_sts;

    function automatic logic [2:0] kind_code(input logic [7:0] ch);
        logic [2:0] code;
        case (ch)
            CHAR_R:  code = OP_READ;
            CHAR_W:  code = OP_WRITE;
            CHAR_D:  code = OP_DISCARD;
            CHAR_F:  code = OP_FLUSH;
            default: code = OP_OTHER;
        endcase
        return code;
    endfunction

endpackage

### sv/irlm_intf.sv
// ----------------------------------------------------------------------------
// Request latency monitor channels
// Valid/ready channels for requests, configuration writes and records.
// ----------------------------------------------------------------------------
interface irlm_req_if;
    logic          valid;
    logic          ready;
    irlm_pkg::t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface irlm_cfg_if;
    logic               valid;
    logic               ready;
    irlm_pkg::t_cfg_idx index;
    logic [63:0]        data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface irlm_rec_if;
    logic          valid;
    logic          ready;
    irlm_pkg::t_rec data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### sv/irlm_datapath.sv
// ----------------------------------------------------------------------------
// Request latency monitor datapath
// Entry table, key scan, latency arithmetic, statistics and record register.
// ----------------------------------------------------------------------------
module irlm_datapath #(
    parameter int TABLE_ENTRIES = irlm_pkg::TABLE_ENTRIES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  irlm_pkg::t_cmd     i_cmd,
    output irlm_pkg::t_sts     o_sts,
    input  irlm_pkg::t_req     i_req_data,
    irlm_cfg_if.sink           i_cfg,
    irlm_rec_if.source         o_rec
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    irlm_pkg::t_entry r_mem [TABLE_ENTRIES];
    irlm_pkg::t_entry r_rd_data;
    irlm_pkg::t_entry r_entry;
    irlm_pkg::t_req   r_item;
    irlm_pkg::t_rec   r_out;

    logic        r_enable;
    logic [22:0] r_tpid;
    logic [63:0] r_minl;

    logic [IDX_W-1:0] r_addr;
    logic             r_addr_done;
    logic [IDX_W-1:0] r_cmp_idx;
    logic             r_cmp_vld;
    logic             r_free_found;
    logic [IDX_W-1:0] r_free_idx;
    logic [IDX_W-1:0] r_slot;

    logic [63:0] r_lat;
    logic [63:0] r_cnt;
    logic [63:0] r_sum;
    logic [63:0] r_peak;
    logic        r_out_vld;

    logic             key_eq;
    logic             hit_now;
    logic             free_now;
    logic             scan_done;
    logic             pass;
    logic             room;
    logic             load;
    logic             mem_we;
    logic [IDX_W-1:0] mem_wa;
    irlm_pkg::t_entry mem_wd;
    logic [63:0]      n_cnt;
    logic [63:0]      n_sum;
    logic [63:0]      n_peak;

    assign key_eq   = (r_rd_data.device == r_item.device) &&
                      (r_rd_data.sector == r_item.sector);
    assign hit_now  = i_cmd.scan && r_cmp_vld && r_rd_data.valid && key_eq;
    assign free_now = i_cmd.scan && r_cmp_vld && !r_rd_data.valid;
    assign scan_done = hit_now || (i_cmd.scan && r_cmp_vld && (r_cmp_idx == LAST_IDX));

    assign pass = ((r_tpid == 23'd0) || (r_entry.pid == r_tpid)) &&
                  ((r_minl == 64'd0) || (r_lat >= r_minl));
    assign room = !r_out_vld || o_rec.ready;
    assign load = i_cmd.report && pass && room;

    assign n_cnt  = r_cnt + 64'd1;
    assign n_sum  = r_sum + r_lat;
    assign n_peak = (r_lat > r_peak) ? r_lat : r_peak;

    always_comb begin
        o_sts.enable      = r_enable;
        o_sts.is_complete = (r_item.action == irlm_pkg::ACT_COMPLETE);
        o_sts.clear_done  = i_cmd.clear && (r_addr == LAST_IDX);
        o_sts.scan_done   = scan_done;
        o_sts.hit         = hit_now;
        o_sts.slot_ok     = hit_now || free_now || r_free_found;
        o_sts.report_done = !pass || room;
    end

    // Single write port shared by the clearing pass, issue stores and frees.
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_slot;
        mem_wd = r_entry;
        if (i_cmd.clear) begin
            mem_we = 1'b1;
            mem_wa = r_addr;
            mem_wd = '0;
        end else if (i_cmd.write) begin
            mem_we              = 1'b1;
            mem_wd.valid        = 1'b1;
            mem_wd.device       = r_item.device;
            mem_wd.sector       = r_item.sector;
            mem_wd.start_time   = r_item.time_ns;
            mem_wd.pid          = r_item.pid;
            mem_wd.op_char      = r_item.op_char;
            mem_wd.sector_count = r_item.sector_count;
            mem_wd.name_low     = r_item.name_low;
            mem_wd.name_high    = r_item.name_high;
        end else if (i_cmd.free) begin
            mem_we       = 1'b1;
            mem_wd.valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr       <= '0;
            r_addr_done  <= 1'b0;
            r_cmp_vld    <= 1'b0;
            r_free_found <= 1'b0;
        end else if (i_cmd.start) begin
            r_addr       <= '0;
            r_addr_done  <= 1'b0;
            r_cmp_vld    <= 1'b0;
            r_free_found <= 1'b0;
        end else if (i_cmd.clear) begin
            if (r_addr != LAST_IDX) begin
                r_addr <= r_addr + 1'b1;
            end
        end else if (i_cmd.scan) begin
            r_cmp_vld <= !r_addr_done;
            if (r_addr == LAST_IDX) begin
                r_addr_done <= 1'b1;
            end else begin
                r_addr <= r_addr + 1'b1;
            end
            if (free_now && !r_free_found) begin
                r_free_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_item <= i_req_data;
        end
        if (i_cmd.scan) begin
            r_cmp_idx <= r_addr;
            if (free_now && !r_free_found) begin
                r_free_idx <= r_cmp_idx;
            end
            if (hit_now) begin
                r_entry <= r_rd_data;
                r_slot  <= r_cmp_idx;
            end else if (scan_done) begin
                r_slot <= r_free_found ? r_free_idx : r_cmp_idx;
            end
        end
        if (i_cmd.free) begin
            r_lat <= r_item.time_ns - r_entry.start_time;
        end
        if (load) begin
            r_out.req_latency    <= r_lat;
            r_out.req_pid        <= r_entry.pid;
            r_out.req_device     <= r_entry.device;
            r_out.req_sector     <= r_entry.sector;
            r_out.req_sectors    <= r_entry.sector_count;
            r_out.op_code        <= irlm_pkg::kind_code(r_entry.op_char);
            r_out.byte_count     <= 41'(r_entry.sector_count) << irlm_pkg::SECTOR_SHIFT;
            r_out.req_name_low   <= r_entry.name_low;
            r_out.req_name_high  <= r_entry.name_high;
            r_out.complete_count <= n_cnt;
            r_out.total_latency  <= n_sum;
            r_out.max_latency    <= n_peak;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_sum     <= '0;
            r_peak    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (load) begin
                r_cnt     <= n_cnt;
                r_sum     <= n_sum;
                r_peak    <= n_peak;
                r_out_vld <= 1'b1;
            end else if (o_rec.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_tpid   <= '0;
            r_minl   <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                irlm_pkg::CFG_ENABLE:      r_enable <= i_cfg.data[0];
                irlm_pkg::CFG_TARGET_PID:  r_tpid   <= i_cfg.data[22:0];
                irlm_pkg::CFG_MIN_LATENCY: r_minl   <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign o_rec.valid = r_out_vld;
    assign o_rec.data  = r_out;

endmodule

### sv/irlm_ctrl.sv
// ----------------------------------------------------------------------------
// Request latency monitor controller
// Sequences clearing, table scan, store, free and record steps.
// ----------------------------------------------------------------------------
`include "io_request_latency_monitor_top_assert.svh"

module irlm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  irlm_pkg::t_sts i_sts,
    output irlm_pkg::t_cmd o_cmd
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_WRITE  = 3'd3;
    localparam logic [2:0] S_FREE   = 3'd4;
    localparam logic [2:0] S_REPORT = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_req_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd.clear  = (r_state == S_CLEAR);
        o_cmd.start  = (r_state == S_IDLE) && i_req_valid && i_sts.enable;
        o_cmd.scan   = (r_state == S_SCAN);
        o_cmd.write  = (r_state == S_WRITE);
        o_cmd.free   = (r_state == S_FREE);
        o_cmd.report = (r_state == S_REPORT);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_sts.clear_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (o_cmd.start) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    if (i_sts.is_complete) begin
                        n_state = i_sts.hit ? S_FREE : S_IDLE;
                    end else begin
                        n_state = i_sts.slot_ok ? S_WRITE : S_IDLE;
                    end
                end
            end
            S_WRITE:  n_state = S_IDLE;
            S_FREE:   n_state = S_REPORT;
            S_REPORT: begin
                if (i_sts.report_done) n_state = S_IDLE;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    `IRLM_ASSERT_NEXT(a_miss_returns_idle, (r_state == S_SCAN) && i_sts.scan_done && i_sts.is_complete && !i_sts.hit, r_state == S_IDLE)
    `IRLM_ASSERT_NEXT(a_free_then_report, r_state == S_FREE, r_state == S_REPORT)
    `IRLM_ASSERT_NEXT(a_store_single_cycle, r_state == S_WRITE, r_state == S_IDLE)
    `IRLM_ASSERT_SAME(a_hit_only_in_scan, i_sts.hit, r_state == S_SCAN)

endmodule

### sv/io_request_latency_monitor_top.sv
// ----------------------------------------------------------------------------
// Request latency monitor, top level
// Pairs block request issue and completion transfers and reports latency.
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload                          Transfer when
//  i_req    in   issue or completion event        valid && ready
//  i_cfg    in   register index and write data    valid && ready (always ready)
//  o_rec    out  latency record with statistics   valid && ready
//
//  After reset the table is cleared, one entry per cycle; no request is
//  taken during that pass. A disabled request is taken and dropped
//  without a scan. An enabled request scans the table through its single
//  read port, one entry per cycle; a matching entry ends the scan early.
//  An issue that finds a slot then passes through a store step, and a
//  completion that hits an entry through a free and a record step; the
//  record step waits while a passing record finds the output register full.
//  A finished record waits in the output register; the next request is taken
//  meanwhile and only a further record stalls until that register drains.
// ----------------------------------------------------------------------------
module io_request_latency_monitor_top #(
    parameter int TABLE_ENTRIES = irlm_pkg::TABLE_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    irlm_req_if.sink    i_req,
    irlm_cfg_if.sink    i_cfg,
    irlm_rec_if.source  o_rec
);

    irlm_pkg::t_cmd cmd;
    irlm_pkg::t_sts sts;
    logic           req_ready;

    // The controller alone decides when a request transfer may happen.
    assign i_req.ready = req_ready;

    irlm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (req_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // The datapath holds the table, the registers and the statistics.
    irlm_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_req_data (i_req.data),
        .i_cfg      (i_cfg),
        .o_rec      (o_rec)
    );

endmodule

### test/irlm_checker.sv
// ----------------------------------------------------------------------------
// Request latency monitor checker
// Watches the request, configuration and record channels, predicts every
// record from its own copy of the table and statistics, and compares each
// record field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module irlm_checker
    import irlm_pkg::*;
#(
    parameter int N_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    irlm_req_if  i_req,
    irlm_cfg_if  i_cfg,
    irlm_rec_if  i_rec,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_records
);

    logic        mon_enable;
    logic [22:0] mon_pid_filter;
    logic [63:0] mon_min_lat;

    t_entry      slots [N_ENTRIES];
    logic [63:0] done_total;
    logic [63:0] lat_total;
    logic [63:0] lat_peak;

    t_rec        pending_recs [$];

    function automatic logic [2:0] decode_kind(input logic [7:0] ch);
        if (ch == CHAR_R) return OP_READ;
        if (ch == CHAR_W) return OP_WRITE;
        if (ch == CHAR_D) return OP_DISCARD;
        if (ch == CHAR_F) return OP_FLUSH;
        return OP_OTHER;
    endfunction

    task automatic check_field(input string nm, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: record field %s expected %h, got %h", $time, nm, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    // Work out what one accepted request does to the table and statistics.
    task automatic track_request(input t_req r);
        int          hit;
        int          free_slot;
        logic [63:0] lat;
        t_rec        rec;
        hit = -1;
        free_slot = -1;
        if (!mon_enable) return;
        for (int i = 0; i < N_ENTRIES; i++) begin
            if (slots[i].valid && slots[i].device == r.device && slots[i].sector == r.sector
                && hit < 0)
                hit = i;
            if (!slots[i].valid && free_slot < 0)
                free_slot = i;
        end
        if (r.action == ACT_ISSUE) begin
            if (hit < 0) hit = free_slot;
            if (hit < 0) return;
            slots[hit] = '{valid: 1'b1, device: r.device, sector: r.sector,
                           start_time: r.time_ns, pid: r.pid, op_char: r.op_char,
                           sector_count: r.sector_count, name_low: r.name_low,
                           name_high: r.name_high};
            return;
        end
        if (hit < 0) return;
        slots[hit].valid = 1'b0;
        lat = r.time_ns - slots[hit].start_time;
        if (mon_pid_filter != 0 && slots[hit].pid != mon_pid_filter) return;
        if (mon_min_lat != 0 && lat < mon_min_lat) return;
        done_total = done_total + 1;
        lat_total  = lat_total + lat;
        if (lat > lat_peak) lat_peak = lat;
        rec.req_latency    = lat;
        rec.req_pid        = slots[hit].pid;
        rec.req_device     = slots[hit].device;
        rec.req_sector     = slots[hit].sector;
        rec.req_sectors    = slots[hit].sector_count;
        rec.op_code        = decode_kind(slots[hit].op_char);
        rec.byte_count     = {slots[hit].sector_count, 9'b0};
        rec.req_name_low   = slots[hit].name_low;
        rec.req_name_high  = slots[hit].name_high;
        rec.complete_count = done_total;
        rec.total_latency  = lat_total;
        rec.max_latency    = lat_peak;
        pending_recs.push_back(rec);
    endtask

    always @(posedge i_clk) begin
        t_rec exp_r;
        t_rec act_r;
        if (!i_rst_n) begin
            mon_enable     = 1'b0;
            mon_pid_filter = '0;
            mon_min_lat    = '0;
            done_total     = '0;
            lat_total      = '0;
            lat_peak       = '0;
            for (int i = 0; i < N_ENTRIES; i++) slots[i].valid = 1'b0;
        end else begin
            if (i_rec.valid && i_rec.ready) begin
                act_r = i_rec.data;
                o_records++;
                if (pending_recs.size() == 0) begin
                    $display("%0t: record with no prediction waiting, got %h", $time, act_r);
                    o_fail_count++;
                end else begin
                    exp_r = pending_recs.pop_front();
                    check_field("req_latency", exp_r.req_latency, act_r.req_latency);
                    check_field("req_pid", exp_r.req_pid, act_r.req_pid);
                    check_field("req_device", exp_r.req_device, act_r.req_device);
                    check_field("req_sector", exp_r.req_sector, act_r.req_sector);
                    check_field("req_sectors", exp_r.req_sectors, act_r.req_sectors);
                    check_field("op_code", exp_r.op_code, act_r.op_code);
                    check_field("byte_count", exp_r.byte_count, act_r.byte_count);
                    check_field("req_name_low", exp_r.req_name_low, act_r.req_name_low);
                    check_field("req_name_high", exp_r.req_name_high, act_r.req_name_high);
                    check_field("complete_count", exp_r.complete_count,
                                act_r.complete_count);
                    check_field("total_latency", exp_r.total_latency, act_r.total_latency);
                    check_field("max_latency", exp_r.max_latency, act_r.max_latency);
                end
            end
            if (i_req.valid && i_req.ready)
                track_request(i_req.data);
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_ENABLE:      mon_enable = i_cfg.data[0];
                    CFG_TARGET_PID:  mon_pid_filter = i_cfg.data[22:0];
                    CFG_MIN_LATENCY: mon_min_lat = i_cfg.data;
                    default: ;
                endcase
            end
        end
        o_pending = pending_recs.size();
    end

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_records    = 0;
    end

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// Request latency monitor testbench
// Drives issue and completion transfers through several register settings,
// with bursty input and a stalling record receiver; a checker beside the
// block predicts and compares every record.
// ----------------------------------------------------------------------------
module testbench;
    import irlm_pkg::*;

    // Index three selects no register; writing it must change nothing.
    localparam t_cfg_idx CFG_SPARE = 2'd3;
    localparam int       POOL_KEYS = 24;
    localparam int       CYCLE_LIMIT = 1000000;
    // Longest time an item may occupy the block: full scan plus overhead.
    localparam int       DRAIN_CYCLES = TABLE_ENTRIES_DEF + 40;

    logic i_clk;
    logic i_rst_n;

    irlm_req_if req_ch ();
    irlm_cfg_if cfg_ch ();
    irlm_rec_if rec_ch ();

    int fail_count;
    int pending;
    int records;
    int items_sent;
    int cfg_writes;
    int cycles;

    // Sender burst state and the long receiver hold-off request.
    int burst_left;
    bit hold_request;

    // Pool of keys used for well-formed issue/completion pairs.
    logic [31:0] pool_dev [POOL_KEYS];
    logic [63:0] pool_sec [POOL_KEYS];
    bit          pool_busy [POOL_KEYS];
    logic [63:0] now_ns;

    io_request_latency_monitor_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .i_cfg   (cfg_ch),
        .o_rec   (rec_ch)
    );

    irlm_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_cfg        (cfg_ch),
        .i_rec        (rec_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_records    (records)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles without finishing", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Record receiver. It switches at random between stall patterns,
    // sometimes taking every record, and once in a while honours a
    // request for a long hold-off, which it counts out itself.
    initial begin
        int mode;
        int mode_left;
        mode = 0;
        mode_left = 0;
        rec_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                rec_ch.ready <= 1'b0;
                repeat (400) @(negedge i_clk);
                hold_request = 1'b0;
            end
            if (mode_left == 0) begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(50, 250);
            end
            mode_left--;
            case (mode)
                0: rec_ch.ready <= 1'b1;
                1: rec_ch.ready <= ($urandom_range(0, 1) == 0);
                2: rec_ch.ready <= ($urandom_range(0, 3) == 0);
                default: rec_ch.ready <= ((cycles % 7) < 4);
            endcase
        end
    end

    function automatic t_req make_req(input logic act, input logic [31:0] dev,
                                      input logic [63:0] sec, input logic [63:0] t,
                                      input logic [22:0] pid, input logic [7:0] ch,
                                      input logic [31:0] cnt);
        t_req r;
        r.action       = act;
        r.device       = dev;
        r.sector       = sec;
        r.time_ns      = t;
        r.pid          = pid;
        r.op_char      = ch;
        r.sector_count = cnt;
        r.name_low     = {$urandom, $urandom};
        r.name_high    = {$urandom, $urandom};
        return r;
    endfunction

    // Offer one request and wait for its transfer. Valid stays high between
    // items of one burst; a gap is only opened when the burst is used up.
    task automatic send_req(input t_req r);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 8);
            if (gap > 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
        burst_left--;
        items_sent++;
    endtask

    // Stop offering and wait until every predicted record has been taken,
    // then give silent items time to leave the block.
    task automatic drain;
        req_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [63:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(negedge i_clk);
        cfg_writes++;
    endtask

    task automatic set_regs(input logic en, input logic [22:0] pid, input logic [63:0] lat);
        write_reg(CFG_ENABLE, {63'b0, en});
        write_reg(CFG_TARGET_PID, {41'b0, pid});
        write_reg(CFG_MIN_LATENCY, lat);
    endtask

    function automatic logic [22:0] pick_pid;
        case ($urandom_range(0, 3))
            0:       return 23'd0;
            1:       return 23'h7FFFFF;
            2:       return 23'd5;
            default: return 23'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_kind;
        case ($urandom_range(0, 4))
            0:       return CHAR_R;
            1:       return CHAR_W;
            2:       return CHAR_D;
            3:       return CHAR_F;
            default: return 8'($urandom);
        endcase
    endfunction

    // Random traffic: mostly issue/completion pairs on pooled keys with
    // random content, the rest completions of unknown keys and stray items.
    task automatic random_traffic(input int n, input bit with_hold, input bit with_pause);
        int   k;
        int   pick;
        t_req r;
        for (int i = 0; i < n; i++) begin
            if (with_hold && i == n / 4) hold_request = 1'b1;
            if (with_pause && i == n / 2) begin
                req_ch.valid <= 1'b0;
                burst_left = 0;
                while (pending != 0) @(negedge i_clk);
                @(negedge i_clk);
            end
            // Time mostly moves on a little; now and then it leaps anywhere,
            // which makes some latencies wrap.
            if ($urandom_range(0, 49) == 0) now_ns = {$urandom, $urandom};
            else now_ns = now_ns + $urandom_range(1, 6000);
            k = $urandom_range(0, POOL_KEYS - 1);
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                r = make_req(pool_busy[k] ? ACT_COMPLETE : ACT_ISSUE, pool_dev[k],
                             pool_sec[k], now_ns, pick_pid(), pick_kind(), $urandom);
                pool_busy[k] = !pool_busy[k];
            end else if (pick < 85) begin
                r = make_req(ACT_COMPLETE, $urandom, {$urandom, $urandom}, now_ns,
                             23'($urandom), 8'($urandom), $urandom);
            end else begin
                r = make_req(1'($urandom_range(0, 1)), pool_dev[k], pool_sec[k],
                             {$urandom, $urandom}, 23'($urandom), 8'($urandom), $urandom);
                pool_busy[k] = (r.action == ACT_ISSUE);
            end
            send_req(r);
        end
        drain();
    endtask

    initial begin
        i_rst_n      = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_ENABLE;
        cfg_ch.data  = '0;
        burst_left   = 0;
        hold_request = 1'b0;
        items_sent   = 0;
        cfg_writes   = 0;
        cycles       = 0;
        now_ns       = 64'd1000;
        for (int i = 0; i < POOL_KEYS; i++) begin
            pool_dev[i]  = (i == 0) ? 32'd0 : (i == 1) ? 32'hFFFFFFFF : $urandom_range(0, 3);
            pool_sec[i]  = (i == 0) ? 64'd0 : (i == 1) ? '1 : {$urandom, $urandom};
            pool_busy[i] = 1'b0;
        end
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Disabled: items pass through and leave no trace in the table.
        send_req(make_req(ACT_ISSUE, 32'd7, 64'd7, 64'd10, 23'd0, CHAR_R, 32'd1));
        send_req(make_req(ACT_COMPLETE, 32'd7, 64'd7, 64'd20, 23'd0, CHAR_R, 32'd1));
        drain();

        // Directed checks with every filter open.
        set_regs(1'b1, 23'd0, 64'd0);
        write_reg(CFG_SPARE, '1);
        send_req(make_req(ACT_ISSUE, 32'd0, 64'd0, 64'd100, 23'd0, CHAR_R, 32'd0));
        send_req(make_req(ACT_ISSUE, 32'hFFFFFFFF, '1, 64'd200, 23'h7FFFFF, CHAR_W,
                          32'hFFFFFFFF));
        send_req(make_req(ACT_ISSUE, 32'd1, 64'd1, 64'd300, 23'd5, CHAR_D, 32'd8));
        send_req(make_req(ACT_ISSUE, 32'd2, 64'd2, 64'd400, 23'd6, CHAR_F, 32'd16));
        send_req(make_req(ACT_ISSUE, 32'd3, 64'd3, '1, 23'd7, 8'hFF, 32'd1));
        // Same key again: the first issue is overwritten.
        send_req(make_req(ACT_ISSUE, 32'd1, 64'd1, 64'd350, 23'd9, 8'h00, 32'd4));
        send_req(make_req(ACT_COMPLETE, 32'd0, 64'd0, 64'd150, 23'd0, 8'h00, 32'd0));
        send_req(make_req(ACT_COMPLETE, 32'hFFFFFFFF, '1, '1, 23'd0, 8'h00, 32'd0));
        send_req(make_req(ACT_COMPLETE, 32'd1, 64'd1, 64'd999, 23'd0, 8'h00, 32'd0));
        send_req(make_req(ACT_COMPLETE, 32'd2, 64'd2, 64'd401, 23'd0, 8'h00, 32'd0));
        // Time running backwards: the latency wraps.
        send_req(make_req(ACT_COMPLETE, 32'd3, 64'd3, 64'd5, 23'd0, 8'h00, 32'd0));
        // Completion of a key that is not in the table, and a repeat of one
        // just freed.
        send_req(make_req(ACT_COMPLETE, 32'd9, 64'd9, 64'd500, 23'd0, 8'h00, 32'd0));
        send_req(make_req(ACT_COMPLETE, 32'd2, 64'd2, 64'd600, 23'd0, 8'h00, 32'd0));
        drain();

        // Filters: both entries are freed, only the first is reported.
        set_regs(1'b1, 23'h7FFFFF, '1);
        send_req(make_req(ACT_ISSUE, 32'd4, 64'd4, 64'd0, 23'h7FFFFF, CHAR_R, 32'd2));
        send_req(make_req(ACT_COMPLETE, 32'd4, 64'd4, '1, 23'd0, 8'h00, 32'd0));
        send_req(make_req(ACT_ISSUE, 32'd4, 64'd4, 64'd0, 23'h7FFFFF, CHAR_R, 32'd2));
        send_req(make_req(ACT_COMPLETE, 32'd4, 64'd4, 64'd1, 23'd0, 8'h00, 32'd0));
        drain();
        set_regs(1'b1, 23'd0, 64'd0);

        // Fill the table, try one more new key, then empty it again.
        for (int i = 0; i <= TABLE_ENTRIES_DEF; i++)
            send_req(make_req(ACT_ISSUE, 32'h100 + i, 64'(i), 64'd1000 + i, 23'(i),
                              pick_kind(), $urandom));
        for (int i = 0; i <= TABLE_ENTRIES_DEF; i++)
            send_req(make_req(ACT_COMPLETE, 32'h100 + i, 64'(i), 64'd5000 + i * 3, 23'd0,
                              8'h00, 32'd0));
        drain();

        // Random phases under different settings. The first includes the
        // long receiver hold-off, the second a pause of the sender.
        random_traffic(140, 1'b1, 1'b0);
        set_regs(1'b1, 23'd5, 64'd0);
        random_traffic(100, 1'b0, 1'b1);
        set_regs(1'b1, 23'd0, 64'd3000);
        random_traffic(100, 1'b0, 1'b0);
        set_regs(1'b0, 23'd0, 64'd0);
        random_traffic(30, 1'b0, 1'b0);
        set_regs(1'b1, 23'h7FFFFF, 64'd1);
        random_traffic(80, 1'b0, 1'b0);
        set_regs(1'b1, 23'd0, 64'd0);
        random_traffic(100, 1'b0, 1'b1);

        // Anything still predicted at this point never arrived.
        if (pending != 0) begin
            $display("%0t: %0d predicted records never arrived", $time, pending);
        end
        $display("Sent %0d requests and %0d register writes; %0d records compared.",
                 items_sent, cfg_writes, records);
        $display("Covered disabled, filtered, overwritten, unmatched, wrapped and full-table cases.");
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
